>>> sv/jars_pkg.sv
// package for the job admission round-robin scheduler
// holds command, config-index, priority and outcome codes, controller states and the default queue depth
// no dependencies
package jars_pkg;

  localparam int unsigned QueueDepthDef = 16;

  localparam logic [1:0] CmdTick    = 2'd0;
  localparam logic [1:0] CmdArrive  = 2'd1;
  localparam logic [1:0] CmdRequest = 2'd2;
  localparam logic [1:0] CmdRelease = 2'd3;

  localparam logic [1:0] CfgTotalMemory  = 2'd0;
  localparam logic [1:0] CfgTotalDevices = 2'd1;
  localparam logic [1:0] CfgTimeQuantum  = 2'd2;

  localparam logic [1:0] PrioHigh = 2'd1;

  localparam logic [3:0] OutNone       = 4'd0;
  localparam logic [3:0] OutReady      = 4'd1;
  localparam logic [3:0] OutHeldHigh   = 4'd2;
  localparam logic [3:0] OutHeldLow    = 4'd3;
  localparam logic [3:0] OutTooBig     = 4'd4;
  localparam logic [3:0] OutFull       = 4'd5;
  localparam logic [3:0] OutGranted    = 4'd6;
  localparam logic [3:0] OutWaiting    = 4'd7;
  localparam logic [3:0] OutReqIgnored = 4'd8;
  localparam logic [3:0] OutReleased   = 4'd9;
  localparam logic [3:0] OutRelIgnored = 4'd10;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StExec   = 5'b00010,
    StIns    = 5'b00100,
    StInsCmp = 5'b01000,
    StSched  = 5'b10000
  } state_e;

endpackage

>>> sv/job_admission_round_robin_scheduler.sv
// job admission and round-robin cpu scheduler, top level
// queues live in synchronous memories; codes and states come from jars_pkg
// depends on jars_pkg
//
// One input transaction is one scheduler tick. A tick runs through accept,
// event evaluation (at most one write to a queue memory), and the scheduling
// step, which reads the ready queue head registered from its memory and may
// write the preempted job back. A job held at high priority adds a sorted
// insert through the hold memory, stepping through StIns and StInsCmp for
// every held entry with a larger run time, which moves up one slot, and then
// writing the new job into the freed slot. A new transaction is accepted while
// the previous result waits; the scheduling step waits until the result
// register is free.
module job_admission_round_robin_scheduler
  import jars_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  job_number_i,
  input  logic [15:0] memory_needed_i,
  input  logic [7:0]  device_count_i,
  input  logic [15:0] run_time_i,
  input  logic [1:0]  priority_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  outcome_o,
  output logic        cpu_busy_o,
  output logic [7:0]  running_job_o,
  output logic [15:0] free_memory_o,
  output logic [7:0]  free_devices_o,
  output logic [4:0]  ready_count_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FW-1:0] FillFull = FW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] PtrLast  = AW'(QUEUE_DEPTH - 1);

  // queue memories
  logic [7:0]  ready_mem [QUEUE_DEPTH];
  logic [23:0] high_mem  [QUEUE_DEPTH];
  logic [7:0]  low_mem   [QUEUE_DEPTH];
  logic [7:0]  wait_mem  [QUEUE_DEPTH];

  state_e state_q, state_d;

  logic [15:0] tot_mem_q, tot_mem_d;
  logic [7:0]  tot_dev_q, tot_dev_d;
  logic [7:0]  quantum_q, quantum_d;
  logic [15:0] mem_left_q, mem_left_d;
  logic [7:0]  dev_left_q, dev_left_d;
  logic [7:0]  timer_q, timer_d;
  logic        cpu_v_q, cpu_v_d;
  logic [7:0]  cpu_job_q, cpu_job_d;

  logic [FW-1:0] rdy_fill_q, rdy_fill_d;
  logic [AW-1:0] rdy_head_q, rdy_head_d;
  logic [AW-1:0] rdy_tail_q, rdy_tail_d;
  logic [FW-1:0] high_fill_q, high_fill_d;
  logic [FW-1:0] low_fill_q, low_fill_d;
  logic [FW-1:0] wait_fill_q, wait_fill_d;
  logic [AW-1:0] ins_idx_q, ins_idx_d;

  logic        fwd_q, fwd_d;
  logic [7:0]  fwd_job_q, fwd_job_d;

  // captured transaction
  logic [1:0]  x_cmd_q;
  logic [7:0]  x_job_q;
  logic [15:0] x_mem_q;
  logic [7:0]  x_dev_q;
  logic [15:0] x_rt_q;
  logic [1:0]  x_prio_q;

  logic [7:0]  rdy_rdata_q;
  logic [23:0] high_rdata_q;

  logic        rdy_we;
  logic [AW-1:0] rdy_waddr;
  logic [7:0]  rdy_wdata;
  logic        high_we;
  logic [AW-1:0] high_waddr;
  logic [23:0] high_wdata;
  logic [AW-1:0] high_raddr;
  logic        low_we;
  logic        wait_we;

  logic        ov_q, ov_d;
  logic [3:0]  res_q, res_d;
  logic [3:0]  o_outcome_q, o_outcome_d;
  logic        o_busy_q, o_busy_d;
  logic [7:0]  o_job_q, o_job_d;
  logic [15:0] o_mem_q, o_mem_d;
  logic [7:0]  o_dev_q, o_dev_d;
  logic [FW-1:0] o_fill_q, o_fill_d;

  logic [8:0]  rel_sum;
  logic        sw;
  logic [7:0]  head_job;
  logic [31:0] fill_w;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    tot_mem_d   = tot_mem_q;
    tot_dev_d   = tot_dev_q;
    quantum_d   = quantum_q;
    mem_left_d  = mem_left_q;
    dev_left_d  = dev_left_q;
    timer_d     = timer_q;
    cpu_v_d     = cpu_v_q;
    cpu_job_d   = cpu_job_q;
    rdy_fill_d  = rdy_fill_q;
    rdy_head_d  = rdy_head_q;
    rdy_tail_d  = rdy_tail_q;
    high_fill_d = high_fill_q;
    low_fill_d  = low_fill_q;
    wait_fill_d = wait_fill_q;
    ins_idx_d   = ins_idx_q;
    fwd_d       = fwd_q;
    fwd_job_d   = fwd_job_q;
    res_d       = res_q;
    ov_d        = ov_q;
    o_outcome_d = o_outcome_q;
    o_busy_d    = o_busy_q;
    o_job_d     = o_job_q;
    o_mem_d     = o_mem_q;
    o_dev_d     = o_dev_q;
    o_fill_d    = o_fill_q;
    rdy_we      = 1'b0;
    rdy_waddr   = rdy_tail_q;
    rdy_wdata   = x_job_q;
    high_we     = 1'b0;
    high_waddr  = ins_idx_q;
    high_wdata  = {x_job_q, x_rt_q};
    high_raddr  = ins_idx_q - AW'(1);
    low_we      = 1'b0;
    wait_we     = 1'b0;
    rel_sum     = {1'b0, dev_left_q} + {1'b0, x_dev_q};
    sw          = !cpu_v_q || (timer_q == quantum_q);
    head_job    = fwd_q ? fwd_job_q : rdy_rdata_q;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgTotalMemory: begin
          tot_mem_d  = cfg_data_i;
          mem_left_d = cfg_data_i;
        end
        CfgTotalDevices: begin
          tot_dev_d  = cfg_data_i[7:0];
          dev_left_d = cfg_data_i[7:0];
        end
        CfgTimeQuantum: quantum_d = cfg_data_i[7:0];
        default: ;
      endcase
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        fwd_d     = 1'b0;
        fwd_job_d = x_job_q;
        res_d     = OutNone;
        state_d   = StSched;
        case (x_cmd_q)
          CmdArrive: begin
            if (x_mem_q > tot_mem_q || x_dev_q > tot_dev_q) begin
              res_d = OutTooBig;
            end else if (x_mem_q <= mem_left_q) begin
              if (rdy_fill_q == FillFull) begin
                res_d = OutFull;
              end else begin
                rdy_we     = 1'b1;
                rdy_wdata  = x_job_q;
                rdy_tail_d = (rdy_tail_q == PtrLast) ? '0 : rdy_tail_q + AW'(1);
                rdy_fill_d = rdy_fill_q + FW'(1);
                fwd_d      = (rdy_fill_q == '0);
                mem_left_d = mem_left_q - x_mem_q;
                res_d      = OutReady;
              end
            end else if (x_prio_q == PrioHigh) begin
              if (high_fill_q == FillFull) begin
                res_d = OutFull;
              end else begin
                high_fill_d = high_fill_q + FW'(1);
                ins_idx_d   = high_fill_q[AW-1:0];
                res_d       = OutHeldHigh;
                state_d     = StIns;
              end
            end else if (low_fill_q == FillFull) begin
              res_d = OutFull;
            end else begin
              low_we     = 1'b1;
              low_fill_d = low_fill_q + FW'(1);
              res_d      = OutHeldLow;
            end
          end
          CmdRequest: begin
            if (!cpu_v_q || cpu_job_q != x_job_q) begin
              res_d = OutReqIgnored;
            end else if (dev_left_q >= x_dev_q) begin
              if (rdy_fill_q == FillFull) begin
                res_d = OutReqIgnored;
              end else begin
                rdy_we     = 1'b1;
                rdy_wdata  = cpu_job_q;
                rdy_tail_d = (rdy_tail_q == PtrLast) ? '0 : rdy_tail_q + AW'(1);
                rdy_fill_d = rdy_fill_q + FW'(1);
                fwd_d      = (rdy_fill_q == '0);
                fwd_job_d  = cpu_job_q;
                dev_left_d = dev_left_q - x_dev_q;
                cpu_v_d    = 1'b0;
                res_d      = OutGranted;
              end
            end else if (wait_fill_q == FillFull) begin
              res_d = OutReqIgnored;
            end else begin
              wait_we     = 1'b1;
              wait_fill_d = wait_fill_q + FW'(1);
              cpu_v_d     = 1'b0;
              res_d       = OutWaiting;
            end
          end
          CmdRelease: begin
            if (!cpu_v_q || cpu_job_q != x_job_q) begin
              res_d = OutRelIgnored;
            end else begin
              dev_left_d = rel_sum[8] ? 8'hff : rel_sum[7:0];
              res_d      = OutReleased;
            end
          end
          default: ;
        endcase
      end
      StIns: begin
        // walk down from the tail, moving larger run times up one slot
        if (ins_idx_q == '0) begin
          high_we = 1'b1;
          state_d = StSched;
        end else begin
          state_d = StInsCmp;
        end
      end
      StInsCmp: begin
        high_we = 1'b1;
        if (high_rdata_q[15:0] > x_rt_q) begin
          high_wdata = high_rdata_q;
          ins_idx_d  = ins_idx_q - AW'(1);
          state_d    = StIns;
        end else begin
          state_d = StSched;
        end
      end
      StSched: begin
        if (!ov_q || out_ready_i) begin
          o_busy_d = cpu_v_q;
          o_job_d  = cpu_v_q ? cpu_job_q : 8'd0;
          o_fill_d = rdy_fill_q;
          if (sw && rdy_fill_q != '0) begin
            rdy_head_d = (rdy_head_q == PtrLast) ? '0 : rdy_head_q + AW'(1);
            if (cpu_v_q) begin
              // preempted job goes to the tail
              rdy_we     = 1'b1;
              rdy_wdata  = cpu_job_q;
              rdy_tail_d = (rdy_tail_q == PtrLast) ? '0 : rdy_tail_q + AW'(1);
            end else begin
              rdy_fill_d = rdy_fill_q - FW'(1);
              o_fill_d   = rdy_fill_q - FW'(1);
            end
            cpu_v_d   = 1'b1;
            cpu_job_d = head_job;
            o_busy_d  = 1'b1;
            o_job_d   = head_job;
          end
          timer_d     = sw ? 8'd2 : timer_q + 8'd1;
          o_outcome_d = res_q;
          o_mem_d     = mem_left_q;
          o_dev_d     = dev_left_q;
          ov_d        = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      tot_mem_q   <= '0;
      tot_dev_q   <= '0;
      quantum_q   <= 8'd1;
      mem_left_q  <= '0;
      dev_left_q  <= '0;
      timer_q     <= 8'd1;
      cpu_v_q     <= 1'b0;
      cpu_job_q   <= '0;
      rdy_fill_q  <= '0;
      rdy_head_q  <= '0;
      rdy_tail_q  <= '0;
      high_fill_q <= '0;
      low_fill_q  <= '0;
      wait_fill_q <= '0;
      ins_idx_q   <= '0;
      fwd_q       <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      tot_mem_q   <= tot_mem_d;
      tot_dev_q   <= tot_dev_d;
      quantum_q   <= quantum_d;
      mem_left_q  <= mem_left_d;
      dev_left_q  <= dev_left_d;
      timer_q     <= timer_d;
      cpu_v_q     <= cpu_v_d;
      cpu_job_q   <= cpu_job_d;
      rdy_fill_q  <= rdy_fill_d;
      rdy_head_q  <= rdy_head_d;
      rdy_tail_q  <= rdy_tail_d;
      high_fill_q <= high_fill_d;
      low_fill_q  <= low_fill_d;
      wait_fill_q <= wait_fill_d;
      ins_idx_q   <= ins_idx_d;
      fwd_q       <= fwd_d;
      ov_q        <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    fwd_job_q   <= fwd_job_d;
    res_q       <= res_d;
    o_outcome_q <= o_outcome_d;
    o_busy_q    <= o_busy_d;
    o_job_q     <= o_job_d;
    o_mem_q     <= o_mem_d;
    o_dev_q     <= o_dev_d;
    o_fill_q    <= o_fill_d;
    if (in_valid_i && in_ready_o) begin
      x_cmd_q  <= command_i;
      x_job_q  <= job_number_i;
      x_mem_q  <= memory_needed_i;
      x_dev_q  <= device_count_i;
      x_rt_q   <= run_time_i;
      x_prio_q <= priority_req_i;
    end
  end

  // ready queue memory, read-before-write; head read while empty is forwarded
  always_ff @(posedge clk_i) begin
    if (rdy_we) begin
      ready_mem[rdy_waddr] <= rdy_wdata;
    end
    rdy_rdata_q <= ready_mem[rdy_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (high_we) begin
      high_mem[high_waddr] <= high_wdata;
    end
    high_rdata_q <= high_mem[high_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (low_we) begin
      low_mem[low_fill_q[AW-1:0]] <= x_job_q;
    end
    if (wait_we) begin
      wait_mem[wait_fill_q[AW-1:0]] <= cpu_job_q;
    end
  end

  assign fill_w = 32'(o_fill_q);

  assign out_valid_o    = ov_q;
  assign outcome_o      = o_outcome_q;
  assign cpu_busy_o     = o_busy_q;
  assign running_job_o  = o_job_q;
  assign free_memory_o  = o_mem_q;
  assign free_devices_o = o_dev_q;
  assign ready_count_o  = fill_w[4:0];

endmodule

>>> tb/sv/jars_checker.sv
// checker for the job admission round-robin scheduler
// predicts each tick's result from observed transactions and compares them
// depends on jars_pkg
module jars_checker
  import jars_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  command_i,
  input  logic [7:0]  job_number_i,
  input  logic [15:0] memory_needed_i,
  input  logic [7:0]  device_count_i,
  input  logic [15:0] run_time_i,
  input  logic [1:0]  priority_req_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  outcome_i,
  input  logic        cpu_busy_i,
  input  logic [7:0]  running_job_i,
  input  logic [15:0] free_memory_i,
  input  logic [7:0]  free_devices_i,
  input  logic [4:0]  ready_count_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = QueueDepthDef;

  typedef struct packed {
    logic [3:0]  outcome;
    logic        busy;
    logic [7:0]  job;
    logic [15:0] mem;
    logic [7:0]  dev;
    logic [4:0]  rcount;
  } tick_result_t;

  tick_result_t sched_results_q[$];

  logic [15:0] tot_mem;
  logic [7:0]  tot_dev, quantum;
  logic [7:0]  ready_q[$];
  logic [23:0] high_q[$];
  logic [7:0]  low_q[$];
  logic [7:0]  wait_q[$];
  logic        cpu_on;
  logic [7:0]  cpu_id;
  logic [15:0] mem_left;
  logic [7:0]  dev_left;
  logic [7:0]  qtimer;

  function automatic logic [3:0] admit(logic [7:0] job, logic [15:0] mem, logic [7:0] dev,
                                       logic [15:0] rt, logic [1:0] prio);
    int pos;
    if (mem > tot_mem || dev > tot_dev) return OutTooBig;
    if (mem <= mem_left) begin
      if (ready_q.size() >= Depth) return OutFull;
      ready_q.insert(ready_q.size(), job);
      mem_left = mem_left - mem;
      return OutReady;
    end
    if (prio == PrioHigh) begin
      if (high_q.size() >= Depth) return OutFull;
      pos = 0;
      // equal run times go behind existing entries
      while (pos < high_q.size() && high_q[pos][15:0] <= rt) pos++;
      high_q.insert(pos, {job, rt});
      return OutHeldHigh;
    end
    if (low_q.size() >= Depth) return OutFull;
    low_q.insert(low_q.size(), job);
    return OutHeldLow;
  endfunction

  function automatic tick_result_t predict_tick(logic [1:0] cmd, logic [7:0] job,
      logic [15:0] mem, logic [7:0] dev, logic [15:0] rt, logic [1:0] prio);
    tick_result_t r;
    logic [3:0] oc;
    logic [7:0] head;
    int sum;
    oc = OutNone;
    case (cmd)
      CmdArrive: oc = admit(job, mem, dev, rt, prio);
      CmdRequest: begin
        if (!cpu_on || cpu_id != job) oc = OutReqIgnored;
        else if (dev_left >= dev) begin
          if (ready_q.size() >= Depth) oc = OutReqIgnored;
          else begin
            dev_left = dev_left - dev;
            ready_q.insert(ready_q.size(), cpu_id);
            cpu_on = 1'b0;
            oc = OutGranted;
          end
        end else if (wait_q.size() >= Depth) oc = OutReqIgnored;
        else begin
          wait_q.insert(wait_q.size(), cpu_id);
          cpu_on = 1'b0;
          oc = OutWaiting;
        end
      end
      CmdRelease: begin
        if (!cpu_on || cpu_id != job) oc = OutRelIgnored;
        else begin
          sum = dev_left + dev;
          dev_left = (sum > 255) ? 8'd255 : sum[7:0];
          oc = OutReleased;
        end
      end
      default: ;
    endcase
    if (!cpu_on || qtimer == quantum) begin
      if (ready_q.size() > 0) begin
        head = ready_q[0];
        ready_q.delete(0);
        if (cpu_on) ready_q.insert(ready_q.size(), cpu_id);
        cpu_id = head;
        cpu_on = 1'b1;
      end
      qtimer = 8'd1;
    end
    qtimer = qtimer + 8'd1;
    r.outcome = oc;
    r.busy = cpu_on;
    r.job = cpu_on ? cpu_id : 8'd0;
    r.mem = mem_left;
    r.dev = dev_left;
    r.rcount = 5'(ready_q.size());
    return r;
  endfunction

  tick_result_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_mem = '0; tot_dev = '0; quantum = 8'd1;
      ready_q.delete(); high_q.delete(); low_q.delete(); wait_q.delete();
      cpu_on = 1'b0; cpu_id = '0; mem_left = '0; dev_left = '0; qtimer = 8'd1;
      sched_results_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgTotalMemory: begin tot_mem = cfg_data_i; mem_left = cfg_data_i; end
          CfgTotalDevices: begin tot_dev = cfg_data_i[7:0]; dev_left = cfg_data_i[7:0]; end
          CfgTimeQuantum: quantum = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        sched_results_q.insert(sched_results_q.size(),
                               predict_tick(command_i, job_number_i, memory_needed_i,
                                            device_count_i, run_time_i, priority_req_i));
      if (out_valid_i && out_ready_i) begin
        got = {outcome_i, cpu_busy_i, running_job_i, free_memory_i, free_devices_i,
               ready_count_i};
        if (sched_results_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = sched_results_q[0];
          sched_results_q.delete(0);
          if (got !== want) begin
            if (fail_count_o < 10)
              $display("mismatch: exp oc=%0d busy=%0d job=%0d mem=%0d dev=%0d rc=%0d  got oc=%0d busy=%0d job=%0d mem=%0d dev=%0d rc=%0d",
                       want.outcome, want.busy, want.job, want.mem, want.dev, want.rcount,
                       got.outcome, got.busy, got.job, got.mem, got.dev, got.rcount);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= sched_results_q.size();
    end
  end
endmodule

>>> tb/sv/job_admission_round_robin_scheduler_tb.sv
// testbench top for the job admission round-robin scheduler
// drives config and tick transactions, instantiates the block and jars_checker
// depends on jars_pkg, jars_checker and the block
module job_admission_round_robin_scheduler_tb;
  import jars_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0, rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0, cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0, in_ready_o;
  logic [1:0]  command_i = '0, priority_req_i = '0;
  logic [7:0]  job_number_i = '0, device_count_i = '0;
  logic [15:0] memory_needed_i = '0, run_time_i = '0;
  logic        out_valid_o, out_ready_i = 1'b0;
  logic [3:0]  outcome_o;
  logic        cpu_busy_o;
  logic [7:0]  running_job_o, free_devices_o;
  logic [15:0] free_memory_o;
  logic [4:0]  ready_count_o;
  int          fail_count, pending;
  int          cycle_count = 0;
  bit          hold_long = 1'b0;

  localparam int CycleLimit = 400000;

  job_admission_round_robin_scheduler dut (.*);

  jars_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .command_i, .job_number_i, .memory_needed_i,
    .device_count_i, .run_time_i, .priority_req_i, .out_valid_i(out_valid_o),
    .out_ready_i, .outcome_i(outcome_o), .cpu_busy_i(cpu_busy_o),
    .running_job_i(running_job_o), .free_memory_i(free_memory_o),
    .free_devices_i(free_devices_o), .ready_count_i(ready_count_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // receiver: random stalls, long hold-off when requested
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_ready_i <= 1'b0;
        for (n = 0; n < 300; n++) @(posedge clk_i);
        hold_long = 1'b0;
      end
      out_ready_i <= ($urandom_range(0, 3) != 0) || (cycle_count % 2000 < 300);
    end
  end

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic send_tick(logic [1:0] cmd, logic [7:0] job, logic [15:0] mem,
                           logic [7:0] dev, logic [15:0] rt, logic [1:0] prio, bit nogap);
    int g;
    g = nogap ? 0 : gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd; job_number_i <= job; memory_needed_i <= mem;
    device_count_i <= dev; run_time_i <= rt; priority_req_i <= prio;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // every result has been taken here and the block is back in idle
    repeat (80) @(posedge clk_i);
  endtask

  task automatic configure(logic [15:0] m, logic [7:0] d, logic [7:0] q);
    write_reg(CfgTotalMemory, m);
    write_reg(CfgTotalDevices, {8'd0, d});
    write_reg(CfgTimeQuantum, {8'd0, q});
    cfg_valid_i <= 1'b0;
  endtask

  // mostly traffic aimed at the running job so requests and releases take effect
  task automatic random_tick(logic [15:0] memtot, bit nogap);
    int sel;
    logic [7:0] job;
    sel = $urandom_range(0, 99);
    job = (running_job_o != 0 && $urandom_range(0, 3) != 0) ? running_job_o
          : 8'($urandom_range(0, 255));
    if (sel < 45)
      send_tick(CmdArrive, 8'($urandom_range(0, 255)),
                16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, memtot / 4)),
                8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 8)),
                16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 7)),
                2'($urandom_range(0, 3)), nogap);
    else if (sel < 65)
      send_tick(CmdRequest, job, 16'($urandom),
                8'($urandom_range(0, 255) >> $urandom_range(0, 7)),
                16'($urandom), 2'($urandom_range(0, 3)), nogap);
    else if (sel < 80)
      send_tick(CmdRelease, job, 16'($urandom), 8'($urandom_range(0, 255)),
                16'($urandom), 2'($urandom_range(0, 3)), nogap);
    else
      send_tick(CmdTick, 8'($urandom_range(0, 255)), 16'($urandom),
                8'($urandom_range(0, 255)), 16'($urandom), 2'($urandom_range(0, 3)), nogap);
  endtask

  initial begin
    int i, p;
    logic [15:0] memtot;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset config, then extremes and special cases
    send_tick(CmdArrive, 8'd1, 16'd0, 8'd0, 16'd0, 2'd0, 0);
    send_tick(CmdArrive, 8'd2, 16'd1, 8'd0, 16'd0, 2'd0, 0);
    drain();
    configure(16'd100, 8'd10, 8'd3);
    send_tick(CmdArrive, 8'd255, 16'd60, 8'd10, 16'd65535, PrioHigh, 0);
    send_tick(CmdArrive, 8'd7, 16'd40, 8'd0, 16'd0, 2'd0, 0);
    send_tick(CmdArrive, 8'd8, 16'd50, 8'd1, 16'd5, PrioHigh, 0);
    send_tick(CmdArrive, 8'd9, 16'd50, 8'd1, 16'd5, PrioHigh, 0);
    send_tick(CmdArrive, 8'd10, 16'd50, 8'd1, 16'd2, PrioHigh, 0);
    send_tick(CmdArrive, 8'd11, 16'd50, 8'd1, 16'd0, 2'd3, 0);
    send_tick(CmdArrive, 8'd12, 16'd101, 8'd0, 16'd0, 2'd2, 0);
    send_tick(CmdArrive, 8'd13, 16'd0, 8'd11, 16'd0, 2'd0, 0);
    send_tick(CmdRequest, running_job_o, 16'hffff, 8'd4, 16'hffff, 2'd3, 0);
    send_tick(CmdRelease, running_job_o, 16'd0, 8'd255, 16'd0, 2'd0, 0);
    send_tick(CmdRequest, running_job_o, 16'd0, 8'd255, 16'd0, 2'd0, 0);
    send_tick(CmdRequest, 8'd0, 16'd0, 8'd0, 16'd0, 2'd0, 0);
    send_tick(CmdRelease, 8'd0, 16'd0, 8'd0, 16'd0, 2'd0, 0);
    send_tick(CmdTick, 8'd255, 16'hffff, 8'd255, 16'hffff, 2'd3, 0);
    drain();

    // random phases over several settings, extremes included
    for (p = 0; p < 8; p++) begin
      case (p)
        0: memtot = 16'd65535;
        1: memtot = 16'd0;
        2: memtot = 16'd200;
        default: memtot = 16'($urandom_range(1, 65535));
      endcase
      configure(memtot, (p == 1) ? 8'd0 : (p == 0) ? 8'd255 : 8'($urandom_range(0, 255)),
                (p == 0) ? 8'd255 : (p == 1) ? 8'd1 : (p == 2) ? 8'd0
                                               : 8'($urandom_range(1, 20)));
      for (i = 0; i < 190; i++) begin
        if (p == 3 && i == 20) hold_long = 1'b1;
        random_tick(memtot, (p == 3 && i >= 20 && i < 60) || (i % 50 < 8));
        if (p == 5 && i == 100) drain();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
